[hw/rtl/tdpt_pkg.sv]
// Shared constants and types for the trial-division prime tester.
package tdpt_pkg;

   // Default width of the number under test.
   localparam int NUM_WIDTH_DEFAULT = 32;

   // Sequencer state encoding.
   typedef logic [1:0] state_type;

   localparam state_type ST_IDLE   = 2'd0;
   localparam state_type ST_DIVIDE = 2'd1;
   localparam state_type ST_CHECK  = 2'd2;

endpackage

[hw/rtl/trial_division_prime_test.sv]
// Trial-division primality tester built around one shared bit-serial divider.
//
// Usage: drive req_candidate and pulse start while busy is low; the number is
// taken at that clock edge. Only the low NUM_WIDTH bits of the candidate are
// tested. The answer appears on rsp_is_prime, marked by rsp_strobe, which is
// high for exactly one cycle. The receiver cannot stall, so it must take every
// result as it comes.
// Zero and one are answered in the cycle after the transfer. Any other number
// is divided by trial divisors 2, 3, 4, ... in turn. Each trial runs the
// restoring divider over all NUM_WIDTH quotient bits in ST_DIVIDE, then checks
// in ST_CHECK. The number of divisors tried, k, is at most about
// 2^(NUM_WIDTH/2). busy stays high until the result is issued, so one number
// is in work at a time.
// A synchronous reset returns the sequencer to idle and drops any number in
// work without issuing a result.
module trial_division_prime_test
   import tdpt_pkg::*;
#(
   parameter int NUM_WIDTH = NUM_WIDTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [NUM_WIDTH-1:0] req_candidate,
   output logic                 rsp_strobe,
   output logic                 rsp_is_prime
);

   localparam int CNT_W = $clog2(NUM_WIDTH);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_WIDTH - 1);

   state_type            state_ff, state_in;
   logic                 strobe_ff, strobe_in;
   logic                 prime_ff, prime_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [NUM_WIDTH-1:0] div_ff, div_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [NUM_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [NUM_WIDTH:0]   trial;
   logic [NUM_WIDTH:0]   diff;
   logic                 accept;

   assign accept = start && !busy;

   // One restoring-division step: shift in the next dividend bit and try to subtract.
   assign trial = {rem_ff, quo_ff[NUM_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   // Sequencer and datapath next-state logic.
   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      prime_in  = prime_ff;
      num_in    = num_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               num_in = req_candidate;
               div_in = NUM_WIDTH'(2);
               quo_in = req_candidate;
               rem_in = '0;
               cnt_in = '0;
               if (req_candidate < NUM_WIDTH'(2)) begin
                  // Zero and one are never prime.
                  strobe_in = 1'b1;
                  prime_in  = 1'b0;
               end else begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (diff[NUM_WIDTH]) begin
               rem_in = trial[NUM_WIDTH-1:0];
               quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b0};
            end else begin
               rem_in = diff[NUM_WIDTH-1:0];
               quo_in = {quo_ff[NUM_WIDTH-2:0], 1'b1};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_STEP) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // The quotient bounds the search: stop once the divisor exceeds it.
            if (div_ff > quo_ff) begin
               strobe_in = 1'b1;
               prime_in  = 1'b1;
               state_in  = ST_IDLE;
            end else if (rem_ff == '0) begin
               strobe_in = 1'b1;
               prime_in  = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               div_in   = div_ff + NUM_WIDTH'(1);
               quo_in   = num_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      prime_ff <= prime_in;
      num_ff   <= num_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      cnt_ff   <= cnt_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_is_prime = prime_ff;

endmodule

[tb/trial_division_prime_test_test.sv]
// Testbench for the trial-division prime tester: directed and random candidates checked live.
`timescale 1ns / 1ps

module trial_division_prime_test_test;
   import tdpt_pkg::*;

   localparam int NUM_BITS = NUM_WIDTH_DEFAULT;
   localparam int RANDOM_ITEMS = 80;
   localparam int IDLE_LIMIT = 500_000;
   localparam int DRAIN_CYCLES = 40;

   // Scoreboard: predicts each answer by trial division and matches the result transfers.
   class prime_scoreboard;
      typedef struct {
         bit [63:0] candidate;
         bit        is_prime;
      } prime_answer_type;

      prime_answer_type answers_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned primes_seen;
      int unsigned most_trials;

      // Counts the divisors tried, so the stimulus can keep run time in check.
      static function bit trial_divide(input bit [63:0] n, output int unsigned trials);
         bit [63:0] d;
         trials = 0;
         if (n < 2) begin
            return 1'b0;
         end
         for (d = 64'd2; d <= n / d; d++) begin
            trials++;
            if (n % d == 0) begin
               return 1'b0;
            end
         end
         return 1'b1;
      endfunction

      function void note_candidate(input bit [NUM_BITS-1:0] number);
         prime_answer_type answer;
         int unsigned trials;
         answer.candidate = 64'(number);
         answer.is_prime = trial_divide(answer.candidate, trials);
         if (trials > most_trials) begin
            most_trials = trials;
         end
         answers_q.push_back(answer);
      endfunction

      function void check_result(input bit got_is_prime);
         prime_answer_type answer;
         if (answers_q.size() == 0) begin
            $error("Result transfer with no candidate in work: is_prime %0b", got_is_prime);
            errors++;
            return;
         end
         answer = answers_q.pop_front();
         checked++;
         if (got_is_prime) begin
            primes_seen++;
         end
         if (got_is_prime !== answer.is_prime) begin
            $error("is_prime mismatch for candidate %0d: expected %0b, actual %0b",
                   answer.candidate, answer.is_prime, got_is_prime);
            errors++;
         end
      endfunction

      function int unsigned pending();
         return answers_q.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [NUM_BITS-1:0] req_candidate;
   logic                rsp_strobe;
   logic                rsp_is_prime;

   prime_scoreboard board = new();
   int unsigned         idle_cycles;
   int unsigned         sent_count;

   trial_division_prime_test #(
      .NUM_WIDTH(NUM_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_candidate(req_candidate),
      .rsp_strobe(rsp_strobe),
      .rsp_is_prime(rsp_is_prime)
   );

   // Free-running clock with an 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Monitor both channels at the rising edge and watch for a hung block.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            board.note_candidate(req_candidate);
            sent_count++;
         end
         if (rsp_strobe) begin
            board.check_result(rsp_is_prime);
         end
         if ((start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout after %0d cycles with no transfer", idle_cycles);
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   // Called at a falling edge; returns at the falling edge after the transfer, start still high.
   task automatic send_candidate(input bit [NUM_BITS-1:0] number);
      req_candidate <= number;
      start <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   // Ends a burst and leaves the request side quiet for a random number of cycles.
   // A zero-length gap keeps start high so the next burst follows at once.
   task automatic pause_sender();
      int unsigned gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Draws a candidate: mostly small numbers, some full-width values and medium ones,
   // rejecting those that would keep the divider busy too long.
   function automatic bit [NUM_BITS-1:0] pick_candidate();
      bit [63:0]   number;
      int unsigned trials;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         number = 64'($urandom_range(0, 4095));
      end else if (pick < 8) begin
         do begin
            number = 64'($urandom);
            void'(prime_scoreboard::trial_divide(number, trials));
         end while (trials > 300);
      end else begin
         do begin
            number = 64'($urandom_range(0, (1 << 20) - 1));
            void'(prime_scoreboard::trial_divide(number, trials));
         end while (trials > 1100);
      end
      return number[NUM_BITS-1:0];
   endfunction

   bit [NUM_BITS-1:0] directed_list[] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97,
      32'd10403, 32'd63001, 32'd65521, 32'd65536, 32'd1000003, 32'd1048573,
      32'd16777213, 32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF
   };

   initial begin
      int unsigned index;
      int unsigned burst;

      reset = 1'b1;
      start = 1'b0;
      req_candidate = '0;
      idle_cycles = 0;
      sent_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: edges of the range, small primes and squares, wide values.
      index = 0;
      while (index < directed_list.size()) begin
         burst = $urandom_range(1, 6);
         while (burst > 0 && index < directed_list.size()) begin
            send_candidate(directed_list[index]);
            index++;
            burst--;
         end
         pause_sender();
      end

      // Random part in bursts of random length.
      index = 0;
      while (index < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         while (burst > 0 && index < RANDOM_ITEMS) begin
            send_candidate(pick_candidate());
            index++;
            burst--;
         end
         pause_sender();
      end
      @(negedge clock);
      start <= 1'b0;

      // Drain the last answer, then allow a little extra time for stray strobes.
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.pending() != 0) begin
         $error("%0d answers never arrived", board.pending());
         board.errors++;
      end
      $display("Tested %0d candidates, %0d answers checked, %0d reported prime.",
               sent_count, board.checked, board.primes_seen);
      $display("Longest search took %0d trial divisors.", board.most_trials);
      if (board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[trial_division_prime_test.f]
hw/rtl/tdpt_pkg.sv
hw/rtl/trial_division_prime_test.sv
tb/trial_division_prime_test_test.sv
